### hdl/electron_tau_cross_trigger_assert.svh
// Assertion macros for the electron / tau-jet cross trigger.
// Included by the checker; expects clk and rst_n in scope.
`ifndef ELECTRON_TAU_CROSS_TRIGGER_ASSERT_SVH
`define ELECTRON_TAU_CROSS_TRIGGER_ASSERT_SVH

// checked only outside reset
`define ETCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ETCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/etct_pkg.sv
// Shared types and constants for the electron / tau-jet cross trigger.
// No dependencies.
package etct_pkg;

  localparam int MAX_ELECTRONS = 16;
  localparam int MAX_JETS      = 16;

  localparam int ELE_CW = $clog2(MAX_ELECTRONS + 1);
  localparam int JET_CW = $clog2(MAX_JETS + 1);
  localparam int ELE_AW = (MAX_ELECTRONS > 1) ? $clog2(MAX_ELECTRONS) : 1;
  localparam int JET_AW = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam int IDX_W  = (ELE_CW > JET_CW) ? ELE_CW : JET_CW;

  localparam int ET_W   = 12;
  localparam int ETA_W  = 11;
  localparam int PHI_W  = 9;
  localparam int BX_W   = 4;
  localparam int CUT_W  = 10;
  localparam int DR_W   = 16;
  localparam int DE_SQ_W = 2 * ETA_W;
  localparam int DP_SQ_W = 2 * PHI_W;
  localparam int SUM_W   = DE_SQ_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ETA_W-1:0] ETA_TOP  = ETA_W'(1344);
  localparam logic [PHI_W-1:0] PHI_HALF = PHI_W'(201);
  localparam logic [PHI_W-1:0] PHI_FULL = PHI_W'(402);

  localparam logic [1:0] ACT_ELE = 2'd0;
  localparam logic [1:0] ACT_JET = 2'd1;
  localparam logic [1:0] ACT_END = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ELE_ET_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU_ET_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELE_ETA_CUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU_ETA_CUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DR_SQ_MIN   = 3'd4;

  typedef struct packed {
    logic [1:0]             action;
    logic [ET_W-1:0]        et;
    logic [ETA_W-1:0]       eta;
    logic [PHI_W-1:0]       phi;
    logic signed [BX_W-1:0] bx;
    logic                   is_tau;
    logic                   zero_bias;
  } in_t;

  typedef struct packed {
    logic fire;
    logic overflow;
  } out_t;

  // one stored object position
  typedef struct packed {
    logic [ETA_W-1:0] eta;
    logic [PHI_W-1:0] phi;
  } pt_t;

endpackage

### hdl/etct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module etct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/etct_dist.sv
// Pipelined squared delta-R unit, shared by every pair comparison.
// Depends on etct_pkg.
module etct_dist
  import etct_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  pt_t             pt_a,
  input  pt_t             pt_b,
  input  logic [DR_W-1:0] dr_sq_min,
  output logic            hit,
  output logic            busy
);

  logic               v1_r, v2_r;
  logic [ETA_W-1:0]   deta_r;
  logic [PHI_W-1:0]   dphi_r;
  logic [DE_SQ_W-1:0] de_sq_r;
  logic [DP_SQ_W-1:0] dp_sq_r;
  logic [ETA_W-1:0]   deta_nxt;
  logic [PHI_W-1:0]   dp_raw, dphi_nxt;
  logic [SUM_W-1:0]   sum;

  always_comb begin
    deta_nxt = (pt_a.eta > pt_b.eta) ? pt_a.eta - pt_b.eta : pt_b.eta - pt_a.eta;
    dp_raw   = (pt_a.phi > pt_b.phi) ? pt_a.phi - pt_b.phi : pt_b.phi - pt_a.phi;
    // wrap at pi
    if (dp_raw > PHI_HALF) begin
      dphi_nxt = (dp_raw > PHI_FULL) ? dp_raw - PHI_FULL : PHI_FULL - dp_raw;
    end else begin
      dphi_nxt = dp_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    deta_r  <= deta_nxt;
    dphi_r  <= dphi_nxt;
    de_sq_r <= DE_SQ_W'(deta_r) * DE_SQ_W'(deta_r);
    dp_sq_r <= DP_SQ_W'(dphi_r) * DP_SQ_W'(dphi_r);
  end

  assign sum  = SUM_W'(de_sq_r) + SUM_W'(dp_sq_r);
  assign hit  = v2_r && (sum > SUM_W'(dr_sq_min));
  assign busy = v1_r || v2_r;

endmodule

### hdl/electron_tau_cross_trigger.sv
// Top level of the electron / tau-jet cross trigger: cuts, object stores,
// sweep sequencer and result register. Depends on etct_pkg, etct_ram, etct_dist.
//
// Usage:
//   in_valid/in_stall/in_data carry electron, jet and end-of-event items.
//   out_valid/out_stall/out_data carry one fire/overflow result per event.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the cut registers; cfg_ready
//   is always high. Write them only while the block is idle.
// Sequencing:
//   A failing object, or one with nothing stored of the other kind, starts no
//   sweep. A qualifying object otherwise sweeps the stored objects of the other
//   kind: the sweep reads one stored object per cycle and feeds the two-stage
//   delta-R unit, then the drain state waits out the last read and both stages.
//   in_stall stays high during the sweep and drain.
//   An end item's result is shown in the cycle after the item is taken.
// Reset: synchronous, active low; cuts go to their defaults, counts and the
//   event flags clear. Store contents are not cleared (read only below count).
// Stall: a pending result is held while out_stall is high; object items are
//   still taken, but a further end item waits until the result leaves.
module electron_tau_cross_trigger
  import etct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN} state_t;

  state_t           state_r;
  logic [ET_W-1:0]  ele_et_min_r, tau_et_min_r;
  logic [CUT_W-1:0] ele_eta_cut_r, tau_eta_cut_r;
  logic [DR_W-1:0]  dr_sq_min_r;

  logic [ELE_CW-1:0] ele_cnt_r;
  logic [JET_CW-1:0] jet_cnt_r;
  logic              pair_hit_r, dropped_r;
  logic [IDX_W-1:0]  idx_r, sweep_cnt_r;
  logic              kind_jet_r;   // 1: new object is a jet, sweep electron store
  logic              rd_valid_r;
  pt_t               obj_r;
  logic              out_valid_r;
  out_t              out_r;

  logic accept, ele_ok, jet_ok, qual_ele, qual_jet, end_acc;
  logic ele_we, jet_we, ele_full, jet_full;
  logic [IDX_W-1:0] other_cnt;
  pt_t  new_pt, ele_rd, jet_rd, stored_pt;
  logic dist_hit, dist_busy;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) ||
                    (out_valid_r && out_stall && in_data.action == ACT_END);

  always_comb begin
    ele_ok = (in_data.bx == '0) &&
             (in_data.eta >= ETA_W'(ele_eta_cut_r)) &&
             (in_data.eta <= ETA_TOP - ETA_W'(ele_eta_cut_r)) &&
             (in_data.et >= ele_et_min_r);
    jet_ok = (in_data.bx == '0) && in_data.is_tau &&
             (in_data.eta >= ETA_W'(tau_eta_cut_r)) &&
             (in_data.eta <= ETA_TOP - ETA_W'(tau_eta_cut_r)) &&
             (in_data.et >= tau_et_min_r);
  end

  assign qual_ele  = accept && (in_data.action == ACT_ELE) && ele_ok;
  assign qual_jet  = accept && (in_data.action == ACT_JET) && jet_ok;
  assign end_acc   = accept && (in_data.action == ACT_END);
  assign ele_full  = (ele_cnt_r == ELE_CW'(MAX_ELECTRONS));
  assign jet_full  = (jet_cnt_r == JET_CW'(MAX_JETS));
  assign ele_we    = qual_ele && !ele_full;
  assign jet_we    = qual_jet && !jet_full;
  assign other_cnt = qual_ele ? IDX_W'(jet_cnt_r) : IDX_W'(ele_cnt_r);
  assign new_pt    = '{eta: in_data.eta, phi: in_data.phi};

  etct_ram #(.WIDTH($bits(pt_t)), .DEPTH(MAX_ELECTRONS)) u_ele_ram (
    .clk   (clk),
    .we    (ele_we),
    .waddr (ele_cnt_r[ELE_AW-1:0]),
    .wdata (new_pt),
    .raddr (idx_r[ELE_AW-1:0]),
    .rdata (ele_rd)
  );

  etct_ram #(.WIDTH($bits(pt_t)), .DEPTH(MAX_JETS)) u_jet_ram (
    .clk   (clk),
    .we    (jet_we),
    .waddr (jet_cnt_r[JET_AW-1:0]),
    .wdata (new_pt),
    .raddr (idx_r[JET_AW-1:0]),
    .rdata (jet_rd)
  );

  assign stored_pt = kind_jet_r ? ele_rd : jet_rd;

  etct_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (rd_valid_r),
    .pt_a      (obj_r),
    .pt_b      (stored_pt),
    .dr_sq_min (dr_sq_min_r),
    .hit       (dist_hit),
    .busy      (dist_busy)
  );

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ele_et_min_r  <= ET_W'(80);
      tau_et_min_r  <= ET_W'(80);
      ele_eta_cut_r <= CUT_W'(288);
      tau_eta_cut_r <= CUT_W'(288);
      dr_sq_min_r   <= DR_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ELE_ET_MIN:  ele_et_min_r  <= cfg_data[ET_W-1:0];
        CFG_TAU_ET_MIN:  tau_et_min_r  <= cfg_data[ET_W-1:0];
        CFG_ELE_ETA_CUT: ele_eta_cut_r <= cfg_data[CUT_W-1:0];
        CFG_TAU_ETA_CUT: tau_eta_cut_r <= cfg_data[CUT_W-1:0];
        CFG_DR_SQ_MIN:   dr_sq_min_r   <= cfg_data[DR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, event state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ele_cnt_r   <= '0;
      jet_cnt_r   <= '0;
      pair_hit_r  <= 1'b0;
      dropped_r   <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= (state_r == ST_SWEEP);
      if (dist_hit) begin
        pair_hit_r <= 1'b1;
      end
      if (end_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (end_acc) begin
            out_r.fire     <= in_data.zero_bias && pair_hit_r;
            out_r.overflow <= dropped_r;
            ele_cnt_r      <= '0;
            jet_cnt_r      <= '0;
            pair_hit_r     <= 1'b0;
            dropped_r      <= 1'b0;
          end
          if (qual_ele || qual_jet) begin
            if (ele_we) begin
              ele_cnt_r <= ele_cnt_r + 1'b1;
            end
            if (jet_we) begin
              jet_cnt_r <= jet_cnt_r + 1'b1;
            end
            if ((qual_ele && ele_full) || (qual_jet && jet_full)) begin
              dropped_r <= 1'b1;
            end
            obj_r       <= new_pt;
            kind_jet_r  <= qual_jet;
            idx_r       <= '0;
            sweep_cnt_r <= other_cnt;
            if (other_cnt != '0) begin
              state_r <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 == sweep_cnt_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_valid_r && !dist_busy) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/etct_chk.sv
// Port-level checker for the cross trigger, bound to the top level.
// Depends on etct_pkg and electron_tau_cross_trigger_assert.svh.
`include "electron_tau_cross_trigger_assert.svh"

module etct_chk
  import etct_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_t                   in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_t                  out_data
);

  logic end_acc;
  assign end_acc = in_valid && !in_stall && (in_data.action == ACT_END);

  `ETCT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")
  `ETCT_ASSERT(a_end_gives_result, end_acc |=> out_valid, "end-of-event transaction gave no result")
  `ETCT_ASSERT(a_result_from_end, $rose(out_valid) |-> $past(end_acc), "result without end-of-event transaction")
  `ETCT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind electron_tau_cross_trigger etct_chk u_etct_chk (.*);

### test/tb_top.sv
// Self-checking testbench for electron_tau_cross_trigger: directed events, then random
// event streams under several cut settings, with random input gaps and output stalls.
// Depends on etct_pkg (hdl/etct_pkg.sv) and the trigger RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import etct_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 32;
  localparam int ET_TOP        = 4095;
  localparam int ETA_ALL_ONES  = 2047;
  localparam int PHI_ALL_ONES  = 511;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  electron_tau_cross_trigger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // trigger state as the testbench sees it
  logic [ET_W-1:0]  ele_et_thr, tau_et_thr;
  logic [CUT_W-1:0] ele_eta_margin, tau_eta_margin;
  logic [DR_W-1:0]  dr_sq_limit;
  pt_t              ele_seen [MAX_ELECTRONS];
  pt_t              jet_seen [MAX_JETS];
  int               n_ele, n_jet;
  bit               pair_found, store_overrun;

  out_t decisions_due [$];

  int items_sent, events_decided, events_fired, events_overflowed;
  int mismatches, cycle_cnt, stall_hold;
  bit quiet;

  function automatic void clear_trigger_state();
    ele_et_thr     = 12'd80;
    tau_et_thr     = 12'd80;
    ele_eta_margin = 10'd288;
    tau_eta_margin = 10'd288;
    dr_sq_limit    = 16'd1024;
    n_ele          = 0;
    n_jet          = 0;
    pair_found     = 1'b0;
    store_overrun  = 1'b0;
  endfunction

  function automatic void apply_cut(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ELE_ET_MIN:  ele_et_thr     = val[ET_W-1:0];
      CFG_TAU_ET_MIN:  tau_et_thr     = val[ET_W-1:0];
      CFG_ELE_ETA_CUT: ele_eta_margin = val[CUT_W-1:0];
      CFG_TAU_ETA_CUT: tau_eta_margin = val[CUT_W-1:0];
      CFG_DR_SQ_MIN:   dr_sq_limit    = val[DR_W-1:0];
      default: ;
    endcase
  endfunction

  // squared delta-R strictly above the limit, phi folded at pi
  function automatic bit wide_pair(pt_t a, pt_t b);
    int de, dp;
    de = int'(a.eta) - int'(b.eta);
    if (de < 0) de = -de;
    dp = int'(a.phi) - int'(b.phi);
    if (dp < 0) dp = -dp;
    if (dp > int'(PHI_HALF))
      dp = (dp > int'(PHI_FULL)) ? dp - int'(PHI_FULL) : int'(PHI_FULL) - dp;
    return de * de + dp * dp > int'(dr_sq_limit);
  endfunction

  function automatic bit eta_ok(logic [ETA_W-1:0] eta, logic [CUT_W-1:0] cut);
    return int'(eta) >= int'(cut) && int'(eta) <= int'(ETA_TOP) - int'(cut);
  endfunction

  // advances the trigger state by one item; returns 1 when the item ends an event
  function automatic bit event_decision(in_t it, output out_t res);
    pt_t p;
    int  i;
    res   = '0;
    p.eta = it.eta;
    p.phi = it.phi;
    case (it.action)
      ACT_END: begin
        res.fire      = it.zero_bias && pair_found;
        res.overflow  = store_overrun;
        n_ele         = 0;
        n_jet         = 0;
        pair_found    = 1'b0;
        store_overrun = 1'b0;
        return 1'b1;
      end
      ACT_ELE: begin
        if (it.bx == 0 && eta_ok(it.eta, ele_eta_margin) && it.et >= ele_et_thr) begin
          for (i = 0; i < n_jet; i++)
            if (wide_pair(p, jet_seen[i])) pair_found = 1'b1;
          if (n_ele < MAX_ELECTRONS) begin
            ele_seen[n_ele] = p;
            n_ele++;
          end else begin
            store_overrun = 1'b1;
          end
        end
      end
      ACT_JET: begin
        if (it.bx == 0 && it.is_tau && eta_ok(it.eta, tau_eta_margin) &&
            it.et >= tau_et_thr) begin
          for (i = 0; i < n_ele; i++)
            if (wide_pair(p, ele_seen[i])) pair_found = 1'b1;
          if (n_jet < MAX_JETS) begin
            jet_seen[n_jet] = p;
            n_jet++;
          end else begin
            store_overrun = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(in_t it);
    int   gap;
    out_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (event_decision(it, res)) decisions_due = {decisions_due, res};
  endtask

  task automatic load_cuts(int ele_et, int tau_et, int ele_cut, int tau_cut, int dr);
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    int i;
    regs = '{CFG_ELE_ET_MIN, CFG_TAU_ET_MIN, CFG_ELE_ETA_CUT, CFG_TAU_ETA_CUT, CFG_DR_SQ_MIN};
    vals = '{CFG_DATA_W'(ele_et), CFG_DATA_W'(tau_et), CFG_DATA_W'(ele_cut),
             CFG_DATA_W'(tau_cut), CFG_DATA_W'(dr)};
    for (i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      apply_cut(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // block is idle once every decision is out and any trailing sweep has drained
  task automatic drain_events();
    in_valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_t obj(logic [1:0] act, int et, int eta, int phi, int bx, bit tau,
                              bit zb);
    in_t it;
    it.action    = act;
    it.et        = ET_W'(et);
    it.eta       = ETA_W'(eta);
    it.phi       = PHI_W'(phi);
    it.bx        = BX_W'(bx);
    it.is_tau    = tau;
    it.zero_bias = zb;
    return it;
  endfunction

  // object passing the current cuts, clustered around an event center half the time
  function automatic in_t good_object(logic [1:0] act, int eta_c, int phi_c);
    int lo, hi, thr, e, p, r;
    lo  = (act == ACT_ELE) ? int'(ele_eta_margin) : int'(tau_eta_margin);
    hi  = int'(ETA_TOP) - lo;
    thr = (act == ACT_ELE) ? int'(ele_et_thr) : int'(tau_et_thr);
    r   = $urandom_range(0, 9);
    if (r < 5) e = eta_c + $urandom_range(0, 80) - 40;
    else if (r < 8) e = $urandom_range(lo, hi);
    else e = (r == 8) ? lo : hi;
    if (e < lo) e = lo;
    if (e > hi) e = hi;
    r = $urandom_range(0, 9);
    if (r < 6) p = (phi_c + $urandom_range(0, 60) + 372) % int'(PHI_FULL);
    else if (r < 9) p = $urandom_range(0, int'(PHI_FULL));
    else p = $urandom_range(0, PHI_ALL_ONES);
    return obj(act, ($urandom_range(0, 3) == 0) ? thr : $urandom_range(thr, ET_TOP), e, p, 0,
               (act == ACT_JET) ? 1'b1 : 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // break one cut, or replace the item by raw noise (any action)
  function automatic in_t spoil(in_t it);
    logic [63:0] raw;
    int lo, hi, thr;
    lo  = (it.action == ACT_ELE) ? int'(ele_eta_margin) : int'(tau_eta_margin);
    hi  = int'(ETA_TOP) - lo;
    thr = (it.action == ACT_ELE) ? int'(ele_et_thr) : int'(tau_et_thr);
    case ($urandom_range(0, 5))
      0: if (thr > 0) it.et = ET_W'($urandom_range(0, thr - 1));
         else it.bx = BX_W'($urandom_range(1, 15));
      1: if (lo > 0) it.eta = ETA_W'($urandom_range(0, lo - 1));
         else it.eta = ETA_W'($urandom_range(hi + 1, ETA_ALL_ONES));
      2: it.eta = ETA_W'($urandom_range(hi + 1, ETA_ALL_ONES));
      3: it.bx = BX_W'($urandom_range(1, 15));
      4: if (it.action == ACT_JET) it.is_tau = 1'b0;
         else it.bx = BX_W'($urandom_range(1, 15));
      default: begin
        raw = {$urandom, $urandom};
        it  = raw[$bits(in_t)-1:0];
      end
    endcase
    return it;
  endfunction

  task automatic run_event(int ele_cnt, int jet_cnt, int noise_pct);
    logic [63:0] raw;
    logic [1:0]  act;
    in_t         it;
    int          eta_c, phi_c;
    eta_c = $urandom_range(0, int'(ETA_TOP));
    phi_c = $urandom_range(0, int'(PHI_FULL) - 1);
    while (ele_cnt + jet_cnt > 0) begin
      if (jet_cnt == 0 || (ele_cnt > 0 &&
          $urandom_range(0, ele_cnt + jet_cnt - 1) < ele_cnt)) begin
        act = ACT_ELE;
        ele_cnt--;
      end else begin
        act = ACT_JET;
        jet_cnt--;
      end
      it = good_object(act, eta_c, phi_c);
      if ($urandom_range(0, 99) < noise_pct) it = spoil(it);
      send_item(it);
    end
    raw          = {$urandom, $urandom};
    it           = raw[$bits(in_t)-1:0];
    it.action    = ACT_END;
    it.zero_bias = ($urandom_range(0, 3) != 0);
    send_item(it);
  endtask

  function automatic int pick_level(int hi, int mid_hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, mid_hi);
    endcase
  endfunction

  task automatic test_directed_defaults();
    // window edges and Et at threshold; zero-bias low blocks the fire
    send_item(obj(ACT_ELE, 80, 288, 0, 0, 1'b0, 1'b1));
    send_item(obj(ACT_JET, 80, 1056, 402, 0, 1'b1, 1'b1));
    send_item(obj(ACT_END, 0, 0, 0, 0, 1'b0, 1'b0));
    // phi 0 against phi 402 folds to no separation
    send_item(obj(ACT_ELE, ET_TOP, 700, 0, 0, 1'b1, 1'b0));
    send_item(obj(ACT_JET, ET_TOP, 700, 402, 0, 1'b1, 1'b0));
    send_item(obj(ACT_END, 0, 0, 0, 0, 1'b0, 1'b1));
    // rejected objects are far away; if any were kept the event would fire
    send_item(obj(ACT_ELE, ET_TOP, 700, 200, 0, 1'b0, 1'b0));
    send_item(obj(ACT_JET, ET_TOP, 1300, 300, 0, 1'b0, 1'b0));
    send_item(obj(ACT_JET, 79, 300, 300, 0, 1'b1, 1'b0));
    send_item(obj(ACT_JET, 500, ETA_ALL_ONES, PHI_ALL_ONES, 0, 1'b1, 1'b1));
    send_item(obj(ACT_JET, 500, 300, 300, -8, 1'b1, 1'b0));
    send_item(obj(ACT_ELE, 79, 300, 100, 0, 1'b1, 1'b0));
    send_item(obj(ACT_ELE, 500, 287, 100, 0, 1'b1, 1'b0));
    send_item(obj(ACT_ELE, 500, 1057, 100, 0, 1'b1, 1'b0));
    send_item(obj(ACT_ELE, 500, 300, 100, 7, 1'b1, 1'b0));
    send_item(obj(ACT_SPARE, ET_TOP, 300, 300, 0, 1'b1, 1'b1));
    send_item(obj(ACT_JET, 500, 700, 210, 0, 1'b1, 1'b0));
    send_item(obj(ACT_END, 0, 0, 0, 0, 1'b0, 1'b1));
    // phi past the full turn, end item with every ignored field set
    send_item(obj(ACT_ELE, 500, 700, PHI_ALL_ONES, 0, 1'b0, 1'b0));
    send_item(obj(ACT_JET, 500, 700, 0, 0, 1'b1, 1'b0));
    send_item(obj(ACT_END, ET_TOP, ETA_ALL_ONES, PHI_ALL_ONES, -1, 1'b1, 1'b1));
  endtask

  task automatic test_dr_threshold();
    // delta eta 32 lands exactly on the default limit, 33 just above it
    send_item(obj(ACT_ELE, 500, 700, 100, 0, 1'b0, 1'b0));
    send_item(obj(ACT_JET, 500, 732, 100, 0, 1'b1, 1'b0));
    send_item(obj(ACT_END, 0, 0, 0, 0, 1'b0, 1'b1));
    send_item(obj(ACT_JET, 500, 733, 100, 0, 1'b1, 1'b0));
    send_item(obj(ACT_ELE, 500, 700, 100, 0, 1'b0, 1'b0));
    send_item(obj(ACT_END, 0, 0, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic test_random_nominal();
    int start;
    drain_events();
    load_cuts(80, 80, 288, 288, 1024);
    start = items_sent;
    while (items_sent - start < 300)
      run_event($urandom_range(0, 5), $urandom_range(0, 5), 15);
  endtask

  task automatic test_open_cuts();
    int start;
    drain_events();
    load_cuts(0, 0, 0, 0, 0);
    start = items_sent;
    while (items_sent - start < 150)
      run_event($urandom_range(0, 4), $urandom_range(0, 4), 20);
  endtask

  task automatic test_tight_cuts();
    int start;
    drain_events();
    load_cuts(ET_TOP, ET_TOP, 672, 672, 65535);
    start = items_sent;
    while (items_sent - start < 100)
      run_event($urandom_range(0, 4), $urandom_range(0, 4), 25);
  endtask

  task automatic test_store_full();
    int start;
    drain_events();
    load_cuts(40, 40, 100, 100, 2500);
    start = items_sent;
    while (items_sent - start < 250)
      run_event($urandom_range(12, 20), $urandom_range(12, 20), 5);
  endtask

  task automatic test_mixed_settings();
    int start, round;
    for (round = 0; round < 4; round++) begin
      drain_events();
      load_cuts(pick_level(ET_TOP, 300), pick_level(ET_TOP, 300), pick_level(672, 672),
                pick_level(672, 672), pick_level(65535, 8192));
      quiet = (round == 2);
      start = items_sent;
      while (items_sent - start < 75)
        run_event($urandom_range(0, 6), $urandom_range(0, 6), 15);
    end
    quiet = 1'b0;
  endtask

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // result side stall: alternate low and high stretches of random length
  always @(posedge clk) begin
    int n;
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_hold = $urandom_range(0, 6);
    end else begin
      n = pick_gap();
      if (n > 0) begin
        out_stall  <= 1'b1;
        stall_hold = n - 1;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      events_decided++;
      if (out_data.fire) events_fired++;
      if (out_data.overflow) events_overflowed++;
      if (decisions_due.size() == 0) begin
        flag($sformatf("decision fire=%0b overflow=%0b with no event pending",
                       out_data.fire, out_data.overflow));
      end else begin
        want = decisions_due.pop_front();
        if (out_data.fire !== want.fire)
          flag($sformatf("fire: expected %0b, got %0b", want.fire, out_data.fire));
        if (out_data.overflow !== want.overflow)
          flag($sformatf("overflow: expected %0b, got %0b", want.overflow, out_data.overflow));
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d decisions outstanding", cycle_cnt,
             decisions_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    clear_trigger_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_defaults();
    test_dr_threshold();
    test_random_nominal();
    test_open_cuts();
    test_tight_cuts();
    test_store_full();
    test_mixed_settings();
    drain_events();
    $display("%0d items sent, %0d events decided: %0d fired, %0d with dropped objects",
             items_sent, events_decided, events_fired, events_overflowed);
    $display("%0d cycles, 9 cut settings incl. reset values, %0d mismatches",
             cycle_cnt, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
